// ===== rtl/core/bblur_pkg.sv =====
`default_nettype none

package bblur_pkg;

    // Register map of the configuration port.
    localparam int CFG_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA  = 2'd2;

    // Frame geometry.
    localparam int ROW_W = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int KERNEL = 5;
    localparam int HALF = KERNEL / 2;
    localparam int LINES = KERNEL - 1;
    localparam int LINE_W = 2;

    // Channel widths: column sums of five pixels and window totals of 25.
    localparam int CA_W = 11;
    localparam int CR_W = 8;
    localparam int CG_W = 9;
    localparam int CB_W = 8;
    localparam int TA_W = 13;
    localparam int TR_W = 10;
    localparam int TG_W = 11;
    localparam int TB_W = 10;

    // floor(x / 25) equals (x * 5243) >> 17 for every x below 43690.
    localparam int MEAN_W = 13;
    localparam logic [MEAN_W-1:0] RECIP_25 = 13'd5243;
    localparam int RECIP_SHIFT = 17;

    typedef struct packed {
        logic [7:0] a;
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
    } px_t;

    typedef struct packed {
        logic [CA_W-1:0] a;
        logic [CR_W-1:0] r;
        logic [CG_W-1:0] g;
        logic [CB_W-1:0] b;
    } csum_t;

    typedef struct packed {
        logic [TA_W-1:0] a;
        logic [TR_W-1:0] r;
        logic [TG_W-1:0] g;
        logic [TB_W-1:0] b;
    } tot_t;

    function automatic logic [7:0] mean25(input logic [MEAN_W-1:0] x);
        logic [2*MEAN_W-1:0] prod;
        prod = (2 * MEAN_W)'(x) * (2 * MEAN_W)'(RECIP_25);
        return prod[RECIP_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/box_blur_5x5_rgb565_unit.sv =====
`default_nettype none

// Streaming 5x5 box blur over RGB565 or ARGB8565 rasters with replicated edges.
// A result passes from the accepted item through the column, window and mean stages into a registered output.
// Throughput: one item per cycle while the output is not stalled; the last item of a row holds the window
// stage while it shifts in the replicated edge columns, and items behind it wait in the column stage.
// Reset clears the counters, all stage valids and the registers (width 1, height 1, RGB565).
// The four line buffers are not cleared; every line is written before a frame reads it.
module box_blur_5x5_rgb565_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [bblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bblur_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              action,
    input  wire logic [7:0]                        in_alpha,
    input  wire logic [4:0]                        in_red,
    input  wire logic [5:0]                        in_green,
    input  wire logic [4:0]                        in_blue,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_alpha,
    output logic [4:0]                             out_red,
    output logic [5:0]                             out_green,
    output logic [4:0]                             out_blue,
    output logic                                   last_of_item,
    output logic                                   frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 2 > bblur_pkg::CFG_W + 1) ? CW + 2 : bblur_pkg::CFG_W + 1;
    localparam int ROW_W = bblur_pkg::ROW_W;
    localparam int RX = bblur_pkg::ROW_W + 1;
    localparam int KERNEL = bblur_pkg::KERNEL;
    localparam int LINES = bblur_pkg::LINES;
    localparam int LINE_W = bblur_pkg::LINE_W;
    localparam int CA_W = bblur_pkg::CA_W;
    localparam int CR_W = bblur_pkg::CR_W;
    localparam int CG_W = bblur_pkg::CG_W;
    localparam int CB_W = bblur_pkg::CB_W;
    localparam int TA_W = bblur_pkg::TA_W;
    localparam int TR_W = bblur_pkg::TR_W;
    localparam int TG_W = bblur_pkg::TG_W;
    localparam int TB_W = bblur_pkg::TB_W;
    localparam int MEAN_W = bblur_pkg::MEAN_W;
    localparam logic [1:0] LAST_STEP = 2'(bblur_pkg::HALF);

    // Configuration and frame counters.
    logic [bblur_pkg::CFG_W-1:0] region_width_reg;
    logic [bblur_pkg::CFG_W-1:0] region_height_reg;
    logic                        alpha_format_reg;
    logic [CW-1:0]               col_cnt_reg;
    logic [ROW_W-1:0]            row_cnt_reg;

    logic [XW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    // Accept side.
    logic             acc;
    logic             acc_work;
    logic             data_row;
    logic             ignore_item;
    logic             row_last;
    logic             frame_end;
    logic [LINE_W-1:0] line_wr;
    logic [LINES-1:0] line_we;
    bblur_pkg::px_t   in_pix;

    // Column stage.
    logic             b_valid_reg;
    logic [ROW_W-1:0] b_row_reg;
    logic [CW-1:0]    b_col_reg;
    bblur_pkg::px_t   b_pix_reg;
    logic             b_data_row_reg;
    logic             b_last_reg;
    bblur_pkg::px_t   line_q_reg [LINES];
    bblur_pkg::px_t   col_px [KERNEL];
    bblur_pkg::csum_t b_cs;
    logic [2:0]       b_emit;
    logic [2:0]       b_fd;
    logic             b_go;
    logic             b_free;

    // Window stage.
    logic             c_valid_reg;
    logic [1:0]       c_step_reg;
    bblur_pkg::csum_t c_cs_reg;
    logic             c_fill_reg;
    logic             c_last_reg;
    logic [2:0]       c_emit_reg;
    logic [2:0]       c_fd_reg;
    bblur_pkg::csum_t win_reg [KERNEL];
    bblur_pkg::tot_t  tot_reg;
    bblur_pkg::tot_t  tot_next;
    logic             emit_now;
    logic             fd_now;
    logic             fill_now;
    logic             c_done;
    logic             c_go;
    logic             c_free;

    // Mean stage and output register.
    logic             d_valid_reg;
    logic             d_last_reg;
    logic             d_frame_reg;
    logic             d_free;
    logic             o_free;
    logic             out_valid_reg;
    logic [7:0]       out_alpha_reg;
    logic [4:0]       out_red_reg;
    logic [5:0]       out_green_reg;
    logic [4:0]       out_blue_reg;
    logic             out_last_reg;
    logic             out_frame_reg;
    logic [7:0]       mean_a;
    logic [7:0]       mean_r;
    logic [7:0]       mean_g;
    logic [7:0]       mean_b;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_width_reg  <= bblur_pkg::CFG_W'(1);
            region_height_reg <= bblur_pkg::CFG_W'(1);
            alpha_format_reg  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                bblur_pkg::REG_WIDTH:  region_width_reg  <= cfg_data;
                bblur_pkg::REG_HEIGHT: region_height_reg <= cfg_data;
                bblur_pkg::REG_ALPHA:  alpha_format_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (region_width_reg == '0)
            w_eff = XW'(1);
        else if (XW'(region_width_reg) > XW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(region_width_reg);

        if (region_height_reg == '0)
            h_eff = ROW_W'(1);
        else if (region_height_reg > ROW_W'(bblur_pkg::HEIGHT_LIMIT))
            h_eff = ROW_W'(bblur_pkg::HEIGHT_LIMIT);
        else
            h_eff = region_height_reg;
    end

    // ------------------------------------------------------------------
    // Accept, counters and line buffers
    // ------------------------------------------------------------------
    assign in_pix      = '{a: in_alpha, r: in_red, g: in_green, b: in_blue};
    assign data_row    = row_cnt_reg < h_eff;
    // A flush item during data rows changes nothing and gives nothing.
    assign ignore_item = data_row && action;
    assign row_last    = XW'(col_cnt_reg) >= w_eff - XW'(1);
    assign frame_end   = RX'(row_cnt_reg) >= RX'(h_eff) + RX'(bblur_pkg::HALF - 1);
    assign line_wr     = row_cnt_reg[LINE_W-1:0];
    assign in_ready    = b_free;
    assign acc         = in_valid && in_ready;
    assign acc_work    = acc && !ignore_item;

    always_comb
    begin
        for (int g = 0; g < LINES; g++)
            line_we[g] = acc_work && data_row && (line_wr == LINE_W'(g));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (acc_work)
        begin
            if (row_last)
            begin
                col_cnt_reg <= '0;
                if (frame_end)
                    row_cnt_reg <= '0;
                else
                    row_cnt_reg <= row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // Every line is read at the item's column; the line being written returns its old row.
    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        bblur_pkg::px_t line_mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (acc_work)
            begin
                if (line_we[g])
                    line_mem[col_cnt_reg] <= in_pix;
                line_q_reg[g] <= line_mem[col_cnt_reg];
            end
        end
    end

    // ------------------------------------------------------------------
    // Column stage: pick the five rows of the column and sum them
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (acc_work)
            b_valid_reg <= 1'b1;
        else if (b_go)
            b_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (acc_work)
        begin
            b_row_reg      <= row_cnt_reg;
            b_col_reg      <= col_cnt_reg;
            b_pix_reg      <= in_pix;
            b_data_row_reg <= data_row;
            b_last_reg     <= row_last;
        end
    end

    always_comb
    begin : column_pick
        logic [RX-1:0] k_val;
        logic [RX-1:0] t_val;
        for (int i = 0; i < KERNEL; i++)
        begin
            // Source row clamped into the frame: rows above the top repeat row zero,
            // rows past the bottom repeat the last row.
            t_val = RX'(b_row_reg) + RX'(i);
            if (t_val < RX'(LINES))
                k_val = '0;
            else
                k_val = t_val - RX'(LINES);
            if (k_val > RX'(h_eff) - RX'(1))
                k_val = RX'(h_eff) - RX'(1);
            if (b_data_row_reg && (k_val == RX'(b_row_reg)))
                col_px[i] = b_pix_reg;
            else
                col_px[i] = line_q_reg[k_val[LINE_W-1:0]];
        end
    end

    always_comb
    begin
        b_cs = '0;
        for (int i = 0; i < KERNEL; i++)
        begin
            b_cs.a = b_cs.a + CA_W'(col_px[i].a);
            b_cs.r = b_cs.r + CR_W'(col_px[i].r);
            b_cs.g = b_cs.g + CG_W'(col_px[i].g);
            b_cs.b = b_cs.b + CB_W'(col_px[i].b);
        end
    end

    always_comb
    begin : emit_flags
        logic row_ok;
        logic frame_row;
        row_ok    = (b_row_reg >= ROW_W'(bblur_pkg::HALF))
                    && (RX'(b_row_reg) < RX'(h_eff) + RX'(bblur_pkg::HALF));
        frame_row = RX'(b_row_reg) == RX'(h_eff) + RX'(bblur_pkg::HALF - 1);
        for (int i = 0; i < 3; i++)
        begin
            b_emit[i] = row_ok && (XW'(b_col_reg) + XW'(i) >= XW'(bblur_pkg::HALF));
            b_fd[i]   = frame_row
                        && (XW'(b_col_reg) + XW'(i) == w_eff + XW'(bblur_pkg::HALF - 1));
        end
    end

    assign b_go   = b_valid_reg && c_free;
    assign b_free = !b_valid_reg || b_go;

    // ------------------------------------------------------------------
    // Window stage: five column sums and their running total
    // ------------------------------------------------------------------
    always_comb
    begin
        case (c_step_reg)
            2'd0:
            begin
                emit_now = c_emit_reg[0];
                fd_now   = c_fd_reg[0];
            end
            2'd1:
            begin
                emit_now = c_emit_reg[1];
                fd_now   = c_fd_reg[1];
            end
            2'd2:
            begin
                emit_now = c_emit_reg[2];
                fd_now   = c_fd_reg[2];
            end
            default:
            begin
                emit_now = 1'b0;
                fd_now   = 1'b0;
            end
        endcase
    end

    // The last item of a row takes two extra steps that shift its column in again.
    assign c_done   = !c_last_reg || (c_step_reg == LAST_STEP);
    assign fill_now = c_fill_reg && (c_step_reg == 2'd0);
    assign c_go     = c_valid_reg && d_free;
    assign c_free   = !c_valid_reg || (c_go && c_done);

    always_comb
    begin
        if (fill_now)
        begin
            tot_next.a = (TA_W'(c_cs_reg.a) << 2) + TA_W'(c_cs_reg.a);
            tot_next.r = (TR_W'(c_cs_reg.r) << 2) + TR_W'(c_cs_reg.r);
            tot_next.g = (TG_W'(c_cs_reg.g) << 2) + TG_W'(c_cs_reg.g);
            tot_next.b = (TB_W'(c_cs_reg.b) << 2) + TB_W'(c_cs_reg.b);
        end
        else
        begin
            tot_next.a = tot_reg.a - TA_W'(win_reg[0].a) + TA_W'(c_cs_reg.a);
            tot_next.r = tot_reg.r - TR_W'(win_reg[0].r) + TR_W'(c_cs_reg.r);
            tot_next.g = tot_reg.g - TG_W'(win_reg[0].g) + TG_W'(c_cs_reg.g);
            tot_next.b = tot_reg.b - TB_W'(win_reg[0].b) + TB_W'(c_cs_reg.b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            c_step_reg  <= 2'd0;
        end
        else if (b_go)
        begin
            c_valid_reg <= 1'b1;
            c_step_reg  <= 2'd0;
        end
        else if (c_go)
        begin
            if (c_done)
            begin
                c_valid_reg <= 1'b0;
                c_step_reg  <= 2'd0;
            end
            else
            begin
                c_step_reg <= c_step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            c_cs_reg   <= b_cs;
            c_fill_reg <= (b_col_reg == '0);
            c_last_reg <= b_last_reg;
            c_emit_reg <= b_emit;
            c_fd_reg   <= b_fd;
        end
        if (c_go)
        begin
            tot_reg <= tot_next;
            for (int i = 0; i < KERNEL - 1; i++)
                win_reg[i] <= fill_now ? c_cs_reg : win_reg[i + 1];
            win_reg[KERNEL - 1] <= c_cs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Mean stage: the total register holds while a result waits here
    // ------------------------------------------------------------------
    assign o_free = !out_valid_reg || out_ready;
    assign d_free = !d_valid_reg || o_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (c_go)
            d_valid_reg <= emit_now;
        else if (o_free)
            d_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (c_go)
        begin
            d_last_reg  <= c_done;
            d_frame_reg <= fd_now;
        end
    end

    assign mean_a = bblur_pkg::mean25(MEAN_W'(tot_reg.a));
    assign mean_r = bblur_pkg::mean25(MEAN_W'(tot_reg.r));
    assign mean_g = bblur_pkg::mean25(MEAN_W'(tot_reg.g));
    assign mean_b = bblur_pkg::mean25(MEAN_W'(tot_reg.b));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (d_valid_reg && o_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (d_valid_reg && o_free)
        begin
            out_alpha_reg <= alpha_format_reg ? mean_a : 8'd0;
            out_red_reg   <= mean_r[4:0];
            out_green_reg <= mean_g[5:0];
            out_blue_reg  <= mean_b[4:0];
            out_last_reg  <= d_last_reg;
            out_frame_reg <= d_frame_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_alpha    = out_alpha_reg;
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;
    assign last_of_item = out_last_reg;
    assign frame_done   = out_frame_reg;

`ifndef SYNTHESIS
    a_extra_steps_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && (c_step_reg != 2'd0) |-> c_last_reg && (c_step_reg <= LAST_STEP))
        else $error("window stage repeats a column of an item that does not end a row");

    a_column_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_free |=> b_valid_reg && $stable(b_col_reg) && $stable(b_row_reg))
        else $error("column stage lost its item while the window stage was busy");

    a_window_total_holds: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg && !o_free |=> d_valid_reg && $stable(tot_reg))
        else $error("window total changed under a waiting result");

    a_one_line_written: assert property (@(posedge clk) disable iff (!rst_n)
        acc_work && data_row |-> $onehot(line_we))
        else $error("a data item must write exactly one line buffer");
`endif

endmodule

`default_nettype wire

// ===== verif/box_blur_5x5_rgb565_checker.sv =====
package bblur_tb_pkg;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } blur_action_t;

endpackage

module box_blur_5x5_rgb565_checker
    import bblur_pkg::*;
    import bblur_tb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   action,
    input  logic [7:0]             in_alpha,
    input  logic [4:0]             in_red,
    input  logic [5:0]             in_green,
    input  logic [4:0]             in_blue,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [7:0]             out_alpha,
    input  logic [4:0]             out_red,
    input  logic [5:0]             out_green,
    input  logic [4:0]             out_blue,
    input  logic                   last_of_item,
    input  logic                   frame_done,
    output int                     mismatch_count,
    output int                     pending_count,
    output int                     checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] a;
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        logic       last;
        logic       done;
    } blur_pixel_t;

    px_t line_mem [LINES][MAX_WIDTH];
    // Window is indexed [column][row]; column 0 is the oldest.
    px_t win [KERNEL][KERNEL];
    px_t incoming [KERNEL];
    int col_cnt;
    int row_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic alpha_reg;
    int mismatches;
    int checked;
    blur_pixel_t caused[$];
    blur_pixel_t expected_pixels[$];

    function automatic blur_pixel_t window_mean(input int y, input int x, input int w,
                                                input int h);
        int sa;
        int sr;
        int sg;
        int sb;
        blur_pixel_t res;
        sa = 0;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int i = 0; i < KERNEL; i++) begin
            for (int j = 0; j < KERNEL; j++) begin
                sa += int'(win[i][j].a);
                sr += int'(win[i][j].r);
                sg += int'(win[i][j].g);
                sb += int'(win[i][j].b);
            end
        end
        res.a = alpha_reg ? 8'(sa / (KERNEL * KERNEL)) : 8'd0;
        res.r = 5'(sr / (KERNEL * KERNEL));
        res.g = 6'(sg / (KERNEL * KERNEL));
        res.b = 5'(sb / (KERNEL * KERNEL));
        res.last = 1'b0;
        res.done = (y == h - 1 && x == w - 1);
        return res;
    endfunction

    task automatic shift_window(input bit fill);
        for (int i = 0; i < KERNEL; i++) begin
            for (int j = 0; j < KERNEL; j++) begin
                if (fill || i == KERNEL - 1) begin
                    win[i][j] = incoming[j];
                end else begin
                    win[i][j] = win[i + 1][j];
                end
            end
        end
    endtask

    task automatic add_result(input int y, input int x, input int w, input int h);
        if (y >= 0 && y < h && x >= 0) begin
            caused.push_back(window_mean(y, x, w, h));
        end
    endtask

    task automatic predict_item(input logic act, input px_t pix_in);
        int w;
        int h;
        int r;
        int c;
        int k;
        bit data_row;
        bit row_end;
        px_t pix;
        blur_pixel_t tail;
        w = int'(width_reg);
        h = int'(height_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        r = row_cnt;
        c = col_cnt;
        if (c > MAX_WIDTH - 1) c = MAX_WIDTH - 1;
        data_row = (r < h);
        // A flush inside the data rows leaves everything untouched.
        if (data_row && act == ACT_FLUSH) return;
        pix = data_row ? pix_in : px_t'(0);
        row_end = (c >= w - 1);
        for (int i = 0; i < KERNEL; i++) begin
            k = r - LINES + i;
            if (k < 0) k = 0;
            if (k > h - 1) k = h - 1;
            incoming[i] = (data_row && k == r) ? pix : line_mem[k % LINES][c];
        end
        if (data_row) line_mem[r % LINES][c] = pix;
        caused.delete();
        shift_window(c == 0);
        add_result(r - HALF, c - HALF, w, h);
        if (row_end) begin
            // The right edge column is repeated to finish the row.
            for (int i = 1; i <= HALF; i++) begin
                shift_window(1'b0);
                add_result(r - HALF, c - HALF + i, w, h);
            end
            col_cnt = 0;
            row_cnt = (r >= h + HALF - 1) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
        if (caused.size() > 0) begin
            tail = caused[caused.size() - 1];
            tail.last = 1'b1;
            caused[caused.size() - 1] = tail;
        end
        foreach (caused[i]) expected_pixels.push_back(caused[i]);
    endtask

    task automatic check_field(input string field, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        blur_pixel_t want;
        if (!rst_n) begin
            for (int i = 0; i < LINES; i++) begin
                for (int j = 0; j < MAX_WIDTH; j++) line_mem[i][j] = '0;
            end
            for (int i = 0; i < KERNEL; i++) begin
                for (int j = 0; j < KERNEL; j++) win[i][j] = '0;
            end
            col_cnt = 0;
            row_cnt = 0;
            width_reg = CFG_W'(1);
            height_reg = CFG_W'(1);
            alpha_reg = 1'b0;
            mismatches = 0;
            checked = 0;
            expected_pixels.delete();
            mismatch_count <= 0;
            pending_count <= 0;
            checked_count <= 0;
        end else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    REG_WIDTH:  width_reg = cfg_data;
                    REG_HEIGHT: height_reg = cfg_data;
                    REG_ALPHA:  alpha_reg = cfg_data[0];
                    default:    ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("blurred pixel arrived with none expected");
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("out_alpha", want.a, out_alpha);
                    check_field("out_red", 8'(want.r), 8'(out_red));
                    check_field("out_green", 8'(want.g), 8'(out_green));
                    check_field("out_blue", 8'(want.b), 8'(out_blue));
                    check_field("last_of_item", 8'(want.last), 8'(last_of_item));
                    check_field("frame_done", 8'(want.done), 8'(frame_done));
                    checked++;
                end
            end
            if (in_valid && in_ready) begin
                predict_item(action, {in_alpha, in_red, in_green, in_blue});
            end
            mismatch_count <= mismatches;
            pending_count <= expected_pixels.size();
            checked_count <= checked;
        end
    end

endmodule

// ===== verif/box_blur_5x5_rgb565_unit_test.sv =====
module box_blur_5x5_rgb565_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bblur_pkg::*;
    import bblur_tb_pkg::*;

    localparam int MAX_WIDTH = 1024;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 12;

    typedef enum {
        PAT_RANDOM,
        PAT_FULL,
        PAT_ZERO,
        PAT_CHECKER
    } fill_pattern_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic action;
    logic [7:0] in_alpha;
    logic [4:0] in_red;
    logic [5:0] in_green;
    logic [4:0] in_blue;
    logic out_valid;
    logic out_ready;
    logic [7:0] out_alpha;
    logic [4:0] out_red;
    logic [5:0] out_green;
    logic [4:0] out_blue;
    logic last_of_item;
    logic frame_done;
    int mismatch_count;
    int pending_count;
    int checked_count;

    int items_accepted = 0;
    int regions_run = 0;
    int cycle_count = 0;
    int hold_requests = 0;
    bit no_idle = 1'b0;

    box_blur_5x5_rgb565_unit #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .in_alpha(in_alpha),
        .in_red(in_red),
        .in_green(in_green),
        .in_blue(in_blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_alpha(out_alpha),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .last_of_item(last_of_item),
        .frame_done(frame_done)
    );

    box_blur_5x5_rgb565_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .in_alpha(in_alpha),
        .in_red(in_red),
        .in_green(in_green),
        .in_blue(in_blue),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_alpha(out_alpha),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .last_of_item(last_of_item),
        .frame_done(frame_done),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count),
        .checked_count(checked_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold so the block backs up into its input.
    initial
    begin
        int holds_done;
        holds_done = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < hold_requests)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (no_idle || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    function automatic px_t frame_pixel(input fill_pattern_t pat, input int x, input int y);
        case (pat)
            PAT_FULL:    return '1;
            PAT_ZERO:    return '0;
            PAT_CHECKER: return ((x + y) % 2 == 0) ? px_t'('1) : px_t'('0);
            default:     return px_t'($urandom);
        endcase
    endfunction

    task automatic offer_item(input blur_action_t act, input px_t p);
        in_valid <= 1'b1;
        action <= act;
        in_alpha <= p.a;
        in_red <= p.r;
        in_green <= p.g;
        in_blue <= p.b;
        do @(posedge clk); while (!in_ready);
        items_accepted++;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Waits until every expected pixel has come out, then lets the pipeline settle.
    task automatic drain_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_region(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic alpha);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= REG_ALPHA;
        cfg_data <= {10'($urandom_range(0, 1023)), alpha};
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_region(input int w_cfg, input int h_cfg, input logic alpha,
                              input fill_pattern_t pat, input bit noisy);
        int w;
        int h;
        set_region(CFG_W'(w_cfg), CFG_W'(h_cfg), alpha);
        w = (w_cfg < 1) ? 1 : (w_cfg > MAX_WIDTH) ? MAX_WIDTH : w_cfg;
        h = (h_cfg < 1) ? 1 : (h_cfg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_cfg;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                // A stray flush between pixels must be ignored.
                if (noisy && $urandom_range(0, 7) == 0) offer_item(ACT_FLUSH, px_t'($urandom));
                offer_item(ACT_PIXEL, frame_pixel(pat, x, y));
            end
        end
        for (int y = 0; y < HALF; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                // Pixels sent during the flush rows count as flush ticks.
                if ($urandom_range(0, 3) == 0) offer_item(ACT_PIXEL, px_t'($urandom));
                else offer_item(ACT_FLUSH, px_t'($urandom));
            end
        end
        drain_block();
        regions_run++;
    endtask

    initial
    begin
        int random_start;
        int w;
        int h;
        bit held;
        fill_pattern_t pat;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= ACT_PIXEL;
        in_alpha <= '0;
        in_red <= '0;
        in_green <= '0;
        in_blue <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Region of one pixel under the reset settings, with both odd cases.
        offer_item(ACT_FLUSH, px_t'($urandom));
        offer_item(ACT_PIXEL, '1);
        offer_item(ACT_FLUSH, px_t'($urandom));
        offer_item(ACT_PIXEL, px_t'($urandom));
        drain_block();
        regions_run++;

        run_region(3, 2, 1'b1, PAT_FULL, 1'b0);
        run_region(2, 2, 1'b1, PAT_CHECKER, 1'b0);

        // Zero in both size registers clamps to a single pixel.
        run_region(0, 0, 1'b0, PAT_RANDOM, 1'b1);

        random_start = items_accepted;
        held = 1'b0;
        while (items_accepted - random_start < RANDOM_ITEMS)
        begin
            if (!held && items_accepted - random_start >= RANDOM_ITEMS / 3)
            begin
                hold_requests++;
                held = 1'b1;
                run_region(16, 6, 1'($urandom_range(0, 1)), PAT_RANDOM, 1'b1);
            end
            else
            begin
                no_idle = (items_accepted - random_start >= RANDOM_ITEMS * 4 / 5);
                w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                pat = ($urandom_range(0, 9) == 0) ? fill_pattern_t'($urandom_range(1, 3))
                                                  : PAT_RANDOM;
                run_region(w, h, 1'($urandom_range(0, 1)), pat, 1'b1);
            end
        end

        repeat (20) @(posedge clk);
        if (pending_count != 0) $error("%0d blurred pixels never arrived", pending_count);
        $display("Ran %0d regions over %0d accepted items in both pixel formats,",
                 regions_run, items_accepted);
        $display("with stray flushes, zero sizes and a long output hold; %0d pixels compared.",
                 checked_count);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bblur_pkg.sv
rtl/core/box_blur_5x5_rgb565_unit.sv
verif/box_blur_5x5_rgb565_checker.sv
verif/box_blur_5x5_rgb565_unit_test.sv
